FILE: design/tmtc_pkg.sv
// ----------------------------------------------------------------------------
// Tempo map time converter package
// Shared item types, tempo point layout and constants of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmtc_pkg;

    // Item kinds.
    localparam logic [1:0] K_INSERT = 2'd0;
    localparam logic [1:0] K_T2N    = 2'd1;
    localparam logic [1:0] K_N2T    = 2'd2;
    localparam logic [1:0] K_NONE   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Tempo limits and the reset tempo, in milli-BPM.
    localparam logic [19:0] TEMPO_MIN     = 20'd1;
    localparam logic [19:0] TEMPO_MAX     = 20'd1000000;
    localparam logic [19:0] DEFAULT_TEMPO = 20'd120000;

    // Nanoseconds per minute, times one thousand.
    localparam logic [63:0] NS_PER_MIN_MILLI = 64'd60000000000000;

    // Input beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] tick_in;
        logic [63:0] ns_in;
        logic [19:0] bpm_in;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic [63:0] result_value;
        logic [1:0]  status;
    } t_out_item;

    // Classified command passed from the front to the back.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] tick;
        logic [63:0] ns;
        logic [19:0] tempo;
    } t_cmd;

    // One tempo point as stored in the table.
    typedef struct packed {
        logic [63:0] tick;
        logic [19:0] tempo;
        logic [63:0] time_ns;
    } t_entry;

endpackage

FILE: design/tempo_map_time_converter.sv
// ----------------------------------------------------------------------------
// Tempo map time converter
// Tick-sorted tempo table with tick/ns conversion and point insertion.
// ----------------------------------------------------------------------------
// Input beats (i_valid / o_stall) carry a kind, a tick, an ns time and a
// tempo. Each beat yields one result beat (o_valid / i_stall) with the
// converted value and a status. A two-entry queue takes beats while the
// sequencer works, and the output register holds a result while the next
// command runs.
// A query scans the table RAM, reading and checking each point in turn,
// then makes one pass through the shared unit (four 32x32 partial products
// and a 64-step restoring division).
// An insert does the same, then writes the point, shifting later points
// up to make room, and recomputes the time of each later point.
// After reset the block writes point 0 (tick 0, 120 BPM,
// time 0). When the receiver stalls, the result waits in the output
// register; one more command may be worked up to its result, then the
// queue fills and o_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tempo_map_time_converter #(
    parameter int MAX_POINTS        = 64,
    parameter int TICKS_PER_QUARTER = 960
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tmtc_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output tmtc_pkg::t_out_item o_item
);

    logic           w_cmd_valid;
    logic           w_cmd_pop;
    tmtc_pkg::t_cmd w_cmd;

    // Front: accept and classify.
    tmtc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    // Back: table sequencer and arithmetic.
    tmtc_back #(
        .MAX_POINTS        (MAX_POINTS),
        .TICKS_PER_QUARTER (TICKS_PER_QUARTER)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

FILE: design/tmtc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tmtc_front.sv
// ----------------------------------------------------------------------------
// Converter front
// Accepts input beats, clamps the tempo and queues commands for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tmtc_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop,
    output tmtc_pkg::t_cmd    o_cmd
);

    tmtc_pkg::t_cmd r_q [2];
    tmtc_pkg::t_cmd n_cmd;
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_fill;
    logic           w_push;
    logic           w_pop;

    // Classify the beat and bring the tempo into range.
    always_comb begin
        n_cmd.kind = i_item.kind;
        n_cmd.tick = i_item.tick_in;
        n_cmd.ns   = i_item.ns_in;
        if (i_item.bpm_in < tmtc_pkg::TEMPO_MIN) begin
            n_cmd.tempo = tmtc_pkg::TEMPO_MIN;
        end else if (i_item.bpm_in > tmtc_pkg::TEMPO_MAX) begin
            n_cmd.tempo = tmtc_pkg::TEMPO_MAX;
        end else begin
            n_cmd.tempo = i_item.bpm_in;
        end
    end

    assign o_stall     = (r_fill == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!w_push && w_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

FILE: design/tmtc_back.sv
// ----------------------------------------------------------------------------
// Converter back
// Sequencer over the tempo table with a shared multiply and divide unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtc_back #(
    parameter int MAX_POINTS        = 64,
    parameter int TICKS_PER_QUARTER = 960
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  tmtc_pkg::t_cmd      i_cmd,
    output logic                o_valid,
    input  logic                i_stall,
    output tmtc_pkg::t_out_item o_item
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = $bits(tmtc_pkg::t_entry);
    localparam logic [15:0] TPQ = 16'(TICKS_PER_QUARTER);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_POINTS);

    // Sequencer states.
    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_SETUP    = 4'd4;
    localparam logic [3:0] S_DEN      = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_CHK      = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_ADD      = 4'd9;
    localparam logic [3:0] S_INS      = 4'd10;
    localparam logic [3:0] S_SHIFT    = 4'd11;
    localparam logic [3:0] S_SHIFT_WR = 4'd12;
    localparam logic [3:0] S_REC_RD   = 4'd13;
    localparam logic [3:0] S_REC_CALC = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    // Where the conversion returns to.
    localparam logic [1:0] R_QUERY = 2'd0;
    localparam logic [1:0] R_INS   = 2'd1;
    localparam logic [1:0] R_REC   = 2'd2;

    logic [3:0]       r_st;
    logic [1:0]       r_ret;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_pos;
    logic             r_eq;
    logic             r_sat;
    logic             r_full;
    tmtc_pkg::t_cmd   r_cmd;
    tmtc_pkg::t_entry r_best;
    tmtc_pkg::t_entry r_prev;
    logic [63:0]      r_ctick;
    logic [19:0]      r_ctempo;
    logic             r_t2n;
    logic [19:0]      r_ftempo;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_d;
    logic [63:0]      r_base;
    logic [127:0]     r_acc;
    logic [63:0]      r_pp;
    logic [1:0]       r_psh;
    logic [2:0]       r_mc;
    logic [63:0]      r_lo;
    logic [63:0]      r_rem;
    logic [63:0]      r_q;
    logic [5:0]       r_dc;
    logic [63:0]      r_at;
    logic [63:0]      r_res;
    logic             r_ov;
    tmtc_pkg::t_out_item r_oitem;

    logic             w_we;
    logic [IW-1:0]    w_waddr;
    tmtc_pkg::t_entry w_wdata;
    logic [IW-1:0]    w_raddr;
    tmtc_pkg::t_entry w_rdata;
    logic [EW-1:0]    w_rbits;
    logic [31:0]      w_ma;
    logic [31:0]      w_mb;
    logic [63:0]      w_pp;
    logic [127:0]     w_ppsh;
    logic [35:0]      w_f;
    logic [64:0]      w_rem2;
    logic [64:0]      w_sum;
    logic [63:0]      w_sumsat;
    logic             w_out_free;

    tmtc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rbits)
    );

    assign w_rdata = tmtc_pkg::t_entry'(w_rbits);

    // One 32 by 32 partial product per cycle.
    always_comb begin
        w_ma = (r_mc[1]) ? r_a[63:32] : r_a[31:0];
        w_mb = (r_mc[0]) ? r_b[63:32] : r_b[31:0];
    end
    assign w_pp = {32'd0, w_ma} * {32'd0, w_mb};

    always_comb begin
        case (r_psh)
            2'd0:    w_ppsh = {64'd0, r_pp};
            2'd3:    w_ppsh = {r_pp, 64'd0};
            default: w_ppsh = {32'd0, r_pp, 32'd0};
        endcase
    end

    // Segment factor, tempo times ticks per quarter.
    assign w_f = {16'd0, r_ftempo} * {20'd0, TPQ};

    // Restoring division step and the saturating base add.
    assign w_rem2   = {r_rem, r_lo[63]};
    assign w_sum    = {1'b0, r_base} + {1'b0, r_q};
    assign w_sumsat = w_sum[64] ? '1 : w_sum[63:0];

    assign w_out_free = !r_ov || !i_stall;
    assign o_cmd_pop  = (r_st == S_IDLE);

    // Table port control.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i[IW-1:0];
        w_wdata = w_rdata;
        w_raddr = r_i[IW-1:0];
        unique case (r_st)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{tick: 64'd0, tempo: tmtc_pkg::DEFAULT_TEMPO, time_ns: 64'd0};
            end
            S_INS: begin
                w_we    = r_eq;
                w_waddr = r_pos[IW-1:0];
                w_wdata = '{tick: r_cmd.tick, tempo: r_cmd.tempo, time_ns: r_at};
            end
            S_SHIFT: begin
                w_we    = (r_i == r_pos);
                w_waddr = r_pos[IW-1:0];
                w_wdata = '{tick: r_cmd.tick, tempo: r_cmd.tempo, time_ns: r_at};
                w_raddr = IW'(r_i - CW'(1));
            end
            S_SHIFT_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
            end
            S_ADD: begin
                w_we    = (r_ret == R_REC);
                w_wdata = '{tick: r_ctick, tempo: r_ctempo, time_ns: w_sumsat};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_INIT;
            r_cnt <= '0;
        end else begin
            unique case (r_st)
                S_INIT: begin
                    r_cnt <= CW'(1);
                    r_st  <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.kind == tmtc_pkg::K_NONE) begin
                            r_st <= S_DONE;
                        end else begin
                            r_st <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    r_st <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    r_st <= (r_i + CW'(1) == r_cnt) ? S_SETUP : S_SCAN_RD;
                end
                S_SETUP: begin
                    r_st <= S_DEN;
                end
                S_DEN: begin
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    if (r_mc == 3'd4) begin
                        r_st <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_st <= (r_acc[127:64] >= r_d) ? S_ADD : S_DIV;
                end
                S_DIV: begin
                    if (r_dc == 6'd63) begin
                        r_st <= S_ADD;
                    end
                end
                S_ADD: begin
                    case (r_ret)
                        R_INS:   r_st <= S_INS;
                        R_REC:   r_st <= S_REC_RD;
                        default: r_st <= S_DONE;
                    endcase
                end
                S_INS: begin
                    if (r_eq) begin
                        r_st <= S_REC_RD;
                    end else if (r_cnt == FULL_CNT) begin
                        r_st <= S_DONE;
                    end else begin
                        r_st <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_i == r_pos) begin
                        r_cnt <= r_cnt + CW'(1);
                        r_st  <= S_REC_RD;
                    end else begin
                        r_st <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_st <= S_SHIFT;
                end
                S_REC_RD: begin
                    r_st <= (r_i >= r_cnt) ? S_DONE : S_REC_CALC;
                end
                S_REC_CALC: begin
                    r_st <= S_DEN;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    // Result valid: set when a result is loaded, cleared when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_st == S_DONE && w_out_free) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_cmd  <= i_cmd;
                r_i    <= '0;
                r_pos  <= '0;
                r_eq   <= 1'b0;
                r_sat  <= 1'b0;
                r_full <= 1'b0;
                r_res  <= 64'd0;
            end
            S_SCAN_CHK: begin
                if (r_cmd.kind == tmtc_pkg::K_N2T) begin
                    if (w_rdata.time_ns <= r_cmd.ns) begin
                        r_best <= w_rdata;
                    end
                end else if (w_rdata.tick <= r_cmd.tick) begin
                    r_best <= w_rdata;
                end
                if (w_rdata.tick < r_cmd.tick) begin
                    r_pos <= r_i + CW'(1);
                end
                if (w_rdata.tick == r_cmd.tick) begin
                    r_eq <= 1'b1;
                end
                r_i <= r_i + CW'(1);
            end
            S_SETUP: begin
                r_ftempo <= r_best.tempo;
                if (r_cmd.kind == tmtc_pkg::K_N2T) begin
                    r_t2n  <= 1'b0;
                    r_a    <= r_cmd.ns - r_best.time_ns;
                    r_base <= r_best.tick;
                    r_ret  <= R_QUERY;
                end else begin
                    r_t2n  <= 1'b1;
                    r_a    <= r_cmd.tick - r_best.tick;
                    r_base <= r_best.time_ns;
                    r_ret  <= (r_cmd.kind == tmtc_pkg::K_INSERT) ? R_INS : R_QUERY;
                end
            end
            S_DEN: begin
                if (r_t2n) begin
                    r_b <= tmtc_pkg::NS_PER_MIN_MILLI;
                    r_d <= 64'(w_f);
                end else begin
                    r_b <= 64'(w_f);
                    r_d <= tmtc_pkg::NS_PER_MIN_MILLI;
                end
                r_acc <= '0;
                r_mc  <= 3'd0;
            end
            S_MUL: begin
                if (r_mc != 3'd4) begin
                    r_pp  <= w_pp;
                    r_psh <= r_mc[1:0];
                end
                if (r_mc != 3'd0) begin
                    r_acc <= r_acc + w_ppsh;
                end
                r_mc <= r_mc + 3'd1;
            end
            S_CHK: begin
                r_rem <= r_acc[127:64];
                r_lo  <= r_acc[63:0];
                r_dc  <= 6'd0;
                if (r_acc[127:64] >= r_d) begin
                    r_q   <= '1;
                    r_sat <= 1'b1;
                end else begin
                    r_q <= 64'd0;
                end
            end
            S_DIV: begin
                if (w_rem2 >= {1'b0, r_d}) begin
                    r_rem <= 64'(w_rem2 - {1'b0, r_d});
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[63:0];
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_lo <= {r_lo[62:0], 1'b0};
                r_dc <= r_dc + 6'd1;
            end
            S_ADD: begin
                if (w_sum[64]) begin
                    r_sat <= 1'b1;
                end
                // A recomputed point keeps the insertion time as the result.
                if (r_ret == R_REC) begin
                    r_prev <= '{tick: r_ctick, tempo: r_ctempo, time_ns: w_sumsat};
                    r_i    <= r_i + CW'(1);
                end else begin
                    r_res <= w_sumsat;
                    r_at  <= w_sumsat;
                end
            end
            S_INS: begin
                r_prev <= '{tick: r_cmd.tick, tempo: r_cmd.tempo, time_ns: r_at};
                if (r_eq) begin
                    r_i <= r_pos + CW'(1);
                end else if (r_cnt == FULL_CNT) begin
                    r_full <= 1'b1;
                    r_res  <= 64'd0;
                end else begin
                    r_i <= r_cnt;
                end
            end
            S_SHIFT: begin
                if (r_i == r_pos) begin
                    r_i <= r_pos + CW'(1);
                end
            end
            S_SHIFT_WR: begin
                r_i <= r_i - CW'(1);
            end
            S_REC_RD: begin
                r_res <= r_at;
            end
            S_REC_CALC: begin
                r_ctick  <= w_rdata.tick;
                r_ctempo <= w_rdata.tempo;
                r_a      <= w_rdata.tick - r_prev.tick;
                r_base   <= r_prev.time_ns;
                r_ftempo <= r_prev.tempo;
                r_t2n    <= 1'b1;
                r_ret    <= R_REC;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_oitem.result_value <= r_res;
                    if (r_full) begin
                        r_oitem.status <= tmtc_pkg::ST_FULL;
                    end else if (r_sat) begin
                        r_oitem.status <= tmtc_pkg::ST_SAT;
                    end else begin
                        r_oitem.status <= tmtc_pkg::ST_OK;
                    end
                end
            end
            default: begin
                r_mc <= r_mc;
            end
        endcase
    end

    assign o_valid = r_ov;
    assign o_item  = r_oitem;

endmodule

FILE: design/tmtc_checker.sv
// ----------------------------------------------------------------------------
// Converter port checker
// Concurrent checks on the converter's ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input tmtc_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input tmtc_pkg::t_out_item o_item
);

    // A stalled input beat holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_item))
        else $error("input beat changed while stalled");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // The unused status code never appears.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.status == tmtc_pkg::ST_OK ||
                     o_item.status == tmtc_pkg::ST_FULL ||
                     o_item.status == tmtc_pkg::ST_SAT))
        else $error("undefined status code");

    // A rejected insert returns zero.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == tmtc_pkg::ST_FULL |-> o_item.result_value == 64'd0)
        else $error("rejected insert with nonzero value");

endmodule

bind tempo_map_time_converter tmtc_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Tempo map time converter testbench
// Inserts tempo points and runs tick/ns queries against the converter, and
// checks every result beat against an in-bench model of the tempo table.
// The sender idles in random bursts and the receiver stalls on its own
// pattern, with two long hold-offs that fill the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int  NPTS      = 64;
    localparam int  TPQ       = 960;
    localparam int  N_RANDOM  = 1600;
    localparam longint CYCLE_LIMIT = 40000000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // One pending beat; a drain beat waits until every result has come.
    typedef struct {
        tmtc_pkg::t_in_item item;
        bit                 drain;
    } t_stim;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    tmtc_pkg::t_in_item  i_item;
    logic                o_valid;
    logic                i_stall;
    tmtc_pkg::t_out_item o_item;

    t_stim               stim_q[$];
    tmtc_pkg::t_out_item expected_results[$];
    logic [63:0]         used_ticks[$];
    int                  errors;
    longint              cycle_count;

    // Tempo table kept by the bench.
    logic [63:0] tm_tick[NPTS];
    logic [19:0] tm_tempo[NPTS];
    logic [63:0] tm_ns[NPTS];
    int          tm_count;

    tempo_map_time_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Exact a * b / d with saturation of the quotient.
    function automatic logic [63:0] scaled_quotient(input logic [63:0] a,
            input logic [63:0] b, input logic [63:0] d, inout bit sat);
        logic [127:0] prod;
        logic [127:0] quo;
        prod = {64'd0, a} * {64'd0, b};
        if (prod[127:64] >= d) begin
            sat = 1'b1;
            return ALL_ONES;
        end
        quo = prod / {64'd0, d};
        return quo[63:0];
    endfunction

    function automatic logic [63:0] clamped_sum(input logic [63:0] a,
            input logic [63:0] b, inout bit sat);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            sat = 1'b1;
            return ALL_ONES;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] span_to_ns(input logic [63:0] ticks,
            input logic [19:0] tempo, inout bit sat);
        logic [63:0] den;
        den = 64'(tempo) * 64'(TPQ);
        if (den == 0) den = 1;
        return scaled_quotient(ticks, tmtc_pkg::NS_PER_MIN_MILLI, den, sat);
    endfunction

    function automatic logic [63:0] time_at_tick(input logic [63:0] t, inout bit sat);
        int k;
        k = 0;
        for (int i = 1; i < tm_count; i++)
            if (tm_tick[i] <= t) k = i;
        return clamped_sum(tm_ns[k], span_to_ns(t - tm_tick[k], tm_tempo[k], sat), sat);
    endfunction

    function automatic logic [63:0] tick_at_time(input logic [63:0] n, inout bit sat);
        int          k;
        logic [63:0] f;
        k = 0;
        for (int i = 1; i < tm_count; i++)
            if (tm_ns[i] <= n) k = i;
        f = 64'(tm_tempo[k]) * 64'(TPQ);
        return clamped_sum(tm_tick[k],
            scaled_quotient(n - tm_ns[k], f, tmtc_pkg::NS_PER_MIN_MILLI, sat), sat);
    endfunction

    // Applies one accepted beat to the table and returns its result.
    function automatic tmtc_pkg::t_out_item convert_and_update(
            input tmtc_pkg::t_in_item it);
        tmtc_pkg::t_out_item r;
        bit                  sat;
        logic [19:0]         tempo;
        logic [63:0]         at;
        int                  pos;
        sat   = 1'b0;
        r     = '0;
        tempo = it.bpm_in;
        if (tempo < tmtc_pkg::TEMPO_MIN) tempo = tmtc_pkg::TEMPO_MIN;
        if (tempo > tmtc_pkg::TEMPO_MAX) tempo = tmtc_pkg::TEMPO_MAX;
        case (it.kind)
            tmtc_pkg::K_INSERT: begin
                at  = time_at_tick(it.tick_in, sat);
                pos = 0;
                while (pos < tm_count && tm_tick[pos] < it.tick_in) pos++;
                if (pos < tm_count && tm_tick[pos] == it.tick_in) begin
                    tm_tempo[pos] = tempo;
                    tm_ns[pos]    = at;
                end else if (tm_count >= NPTS) begin
                    r.status = tmtc_pkg::ST_FULL;
                end else begin
                    for (int i = tm_count; i > pos; i--) begin
                        tm_tick[i]  = tm_tick[i-1];
                        tm_tempo[i] = tm_tempo[i-1];
                        tm_ns[i]    = tm_ns[i-1];
                    end
                    tm_tick[pos]  = it.tick_in;
                    tm_tempo[pos] = tempo;
                    tm_ns[pos]    = at;
                    tm_count++;
                end
                if (r.status == tmtc_pkg::ST_OK) begin
                    r.result_value = at;
                    for (int i = pos + 1; i < tm_count; i++)
                        tm_ns[i] = clamped_sum(tm_ns[i-1],
                            span_to_ns(tm_tick[i] - tm_tick[i-1], tm_tempo[i-1], sat), sat);
                    if (sat) r.status = tmtc_pkg::ST_SAT;
                end
            end
            tmtc_pkg::K_T2N: begin
                r.result_value = time_at_tick(it.tick_in, sat);
                r.status       = sat ? tmtc_pkg::ST_SAT : tmtc_pkg::ST_OK;
            end
            tmtc_pkg::K_N2T: begin
                r.result_value = tick_at_time(it.ns_in, sat);
                r.status       = sat ? tmtc_pkg::ST_SAT : tmtc_pkg::ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Ticks mostly in a musical range, sometimes anywhere.
    function automatic logic [63:0] pick_tick();
        case ($urandom_range(0, 9))
            0:       return rand64();
            1, 2:    return 64'($urandom());
            3, 4:    return (used_ticks.size() > 0) ?
                         used_ticks[$urandom_range(0, used_ticks.size() - 1)] : 64'd0;
            default: return 64'($urandom_range(0, 2000000));
        endcase
    endfunction

    function automatic logic [63:0] pick_ns();
        case ($urandom_range(0, 7))
            0:       return rand64();
            1:       return 64'($urandom()) << $urandom_range(0, 31);
            default: return 64'($urandom_range(0, 2000000)) * 64'd1000;
        endcase
    endfunction

    function automatic logic [19:0] pick_tempo();
        case ($urandom_range(0, 9))
            0:       return 20'($urandom());
            1:       return tmtc_pkg::TEMPO_MAX;
            default: return 20'($urandom_range(30000, 300000));
        endcase
    endfunction

    task automatic add_beat(input logic [1:0] kind, input logic [63:0] tick,
            input logic [63:0] ns, input logic [19:0] bpm, input bit drain);
        t_stim s;
        s.item.kind    = kind;
        s.item.tick_in = tick;
        s.item.ns_in   = ns;
        s.item.bpm_in  = bpm;
        s.drain        = drain;
        stim_q = {stim_q, s};
        if (kind == tmtc_pkg::K_INSERT) used_ticks = {used_ticks, tick};
    endtask

    // Stimulus, then the wait for the last result.
    initial begin
        logic [1:0] kind;
        int         r;
        i_rst_n = 1'b0;
        errors  = 0;
        tm_tick  = '{default: '0};
        tm_tempo = '{default: '0};
        tm_ns    = '{default: '0};
        tm_tempo[0] = tmtc_pkg::DEFAULT_TEMPO;
        tm_count    = 1;

        // Directed beats: point zero, extremes, tempo clamps and unused kind.
        add_beat(tmtc_pkg::K_T2N,    64'd0,    64'd0, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_T2N,    64'd960,  ALL_ONES, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_N2T,    64'd0,    64'd500000000, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_INSERT, 64'd0,    64'd0, 20'd60000, 1'b0);
        add_beat(tmtc_pkg::K_INSERT, 64'd1920, 64'd0, 20'd240000, 1'b0);
        add_beat(tmtc_pkg::K_INSERT, 64'd960,  64'd0, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_INSERT, 64'd3840, 64'd0, 20'hFFFFF, 1'b0);
        add_beat(tmtc_pkg::K_INSERT, 64'd5000, ALL_ONES, tmtc_pkg::TEMPO_MAX, 1'b0);
        add_beat(tmtc_pkg::K_T2N,    64'd1000, 64'd0, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_T2N,    64'd4000, 64'd0, 20'hFFFFF, 1'b0);
        add_beat(tmtc_pkg::K_T2N,    ALL_ONES, 64'd0, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_N2T,    ALL_ONES, 64'd0, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_N2T,    64'd0,    ALL_ONES, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_N2T,    64'd0,    64'd2000000000, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_NONE,   ALL_ONES, ALL_ONES, 20'hFFFFF, 1'b1);
        add_beat(tmtc_pkg::K_NONE,   64'd0,    64'd0, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_INSERT, 64'h8000_0000_0000_0000, 64'd0, 20'd1, 1'b0);
        add_beat(tmtc_pkg::K_T2N,    64'h8000_0000_0000_0001, 64'd0, 20'd0, 1'b0);
        add_beat(tmtc_pkg::K_INSERT, 64'd1920, 64'd0, 20'd100000, 1'b1);

        // Random beats: mostly queries, inserts fill and then overflow the table.
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25)      kind = tmtc_pkg::K_INSERT;
            else if (r < 60) kind = tmtc_pkg::K_T2N;
            else if (r < 97) kind = tmtc_pkg::K_N2T;
            else             kind = tmtc_pkg::K_NONE;
            add_beat(kind, pick_tick(), pick_ns(), pick_tempo(), (n % 400) == 399);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Sender: bursts of beats with random gaps.
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_item     <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end else begin
            if (i_valid && !o_stall)
                expected_results = {expected_results, convert_and_update(i_item)};
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (stim_q.size() > 0 &&
                             !(stim_q[0].drain && expected_results.size() > 0)) begin
                    i_item  <= stim_q[0].item;
                    i_valid <= 1'b1;
                    stim_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a randomly chosen stall pattern, plus long hold-offs.
    int  results_seen;
    int  hold_left;
    int  stall_mode;
    bit  hold_done_a;
    bit  hold_done_b;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            hold_left   <= 0;
            stall_mode  <= 0;
            hold_done_a <= 1'b0;
            hold_done_b <= 1'b0;
        end else begin
            if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
            if (!hold_done_a && results_seen >= 150) begin
                hold_done_a <= 1'b1;
                hold_left   <= 3000;
                i_stall     <= 1'b1;
            end else if (!hold_done_b && results_seen >= 900) begin
                hold_done_b <= 1'b1;
                hold_left   <= 5000;
                i_stall     <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else begin
                case (stall_mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        tmtc_pkg::t_out_item want;
        if (!i_rst_n) begin
            results_seen <= 0;
        end else if (o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: value %0d status %0d",
                       o_item.result_value, o_item.status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_item.result_value !== want.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, o_item.result_value);
                    errors++;
                end
                if (o_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_item.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

endmodule
